// ===== rtl/bba_pkg.sv =====
// Package for the bitmap block allocator: request and response beats,
// status and operation codes, controller states and sizing constants.
// No dependencies.
package bba_pkg;

  localparam int NUM_BLOCKS_DEFAULT = 1024;
  localparam int FIELD_LIMIT        = 1024;
  localparam int WORD_BITS          = 32;
  localparam int BLOCK_W            = 10;
  localparam int LIMIT_W            = 11;
  localparam int WIDX_W             = BLOCK_W - $clog2(WORD_BITS);

  localparam logic [LIMIT_W-1:0] TOTAL_BLOCKS_RESET = LIMIT_W'(1024);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_CHK
  } ctrl_state_t;

  typedef struct packed {
    logic               operation;
    logic [BLOCK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] allocated_block;
    logic [1:0]         status;
  } rsp_t;

  // Lowest set bit of a word; found is low when the word is all zero.
  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } low_bit_t;

  function automatic low_bit_t find_low(input logic [WORD_BITS-1:0] w);
    low_bit_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r.found = 1'b1;
        r.idx   = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/bba_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bitmap_block_allocator_top.sv =====
// Bitmap block allocator, first fit: one used bit per block in a word RAM.
// Allocate reads the 32-bit words from word zero upward, one RAM read per word (1 to 32 words),
// stopping at the first free bit below the limit; no new request is accepted before its result beat.
// Free reads the block's word, then checks and clears its bit; range errors and an empty limit answer without a read.
// The done strobe lasts one cycle and cannot be stalled. Synchronous reset
// marks every block free at once through per-word valid bits; no clear pass.
// Depends on bba_pkg and bba_ram.
module bitmap_block_allocator_top #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bba_pkg::req_t req,
  output logic          done,
  output bba_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  import bba_pkg::*;

  // Blocks past the 10-bit field can never be named, so store only those below.
  localparam int CAP       = (NUM_BLOCKS < FIELD_LIMIT) ? NUM_BLOCKS : FIELD_LIMIT;
  localparam int MEM_WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [LIMIT_W-1:0] CAP_L = LIMIT_W'(CAP);

  // Configuration register
  logic [LIMIT_W-1:0] total_blocks;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32 - LIMIT_W){1'b0}}, total_blocks};

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= TOTAL_BLOCKS_RESET;
    end else if (cfg_wr) begin
      total_blocks <= pwdata[LIMIT_W-1:0];
    end
  end

  // Effective limit and the last word that holds a block below it
  logic [LIMIT_W-1:0] lim;
  logic [LIMIT_W-1:0] lim_m1;
  logic [WIDX_W-1:0]  last_word;

  assign lim       = (total_blocks > CAP_L) ? CAP_L : total_blocks;
  assign lim_m1    = lim - LIMIT_W'(1);
  assign last_word = lim_m1[LIMIT_W-2:5];

  // Controller registers
  ctrl_state_t        state, state_next;
  logic [BLOCK_W-1:0] blk_q;
  logic [WIDX_W-1:0]  cur, cur_next;
  logic               rd_valid;
  logic               done_next;
  rsp_t               rsp_next;

  // RAM and per-word valid bits
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_q;
  logic [MEM_WORDS-1:0] word_valid;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_WORDS),
    .AW    (AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // A word never written since reset reads as all free.
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] in_rng;
  logic [WORD_BITS-1:0] avail;
  low_bit_t             hit;

  assign word = rd_valid ? ram_q : '0;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      in_rng[j] = {1'b0, cur, 5'(j)} < lim;
    end
  end

  assign avail = ~word & in_rng;
  assign hit   = find_low(avail);

  assign busy = (state != S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req.operation == OP_ALLOC) begin
            state_next = (lim == '0) ? S_IDLE : S_SCAN;
          end else begin
            state_next = ({1'b0, req.block_number} >= lim) ? S_IDLE : S_FREE_CHK;
          end
        end
      end
      S_SCAN: begin
        if (hit.found || cur == last_word) begin
          state_next = S_IDLE;
        end
      end
      S_FREE_CHK: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs: RAM control, scan pointer, result beat
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(cur);
    ram_wdata = word;
    ram_re    = 1'b0;
    ram_raddr = AW'(cur);
    cur_next  = cur;
    done_next = 1'b0;
    rsp_next  = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req.operation == OP_ALLOC) begin
            if (lim == '0) begin
              done_next       = 1'b1;
              rsp_next.status = ST_FULL;
            end else begin
              // Fetch word zero and start the scan
              ram_re    = 1'b1;
              ram_raddr = '0;
              cur_next  = '0;
            end
          end else if ({1'b0, req.block_number} >= lim) begin
            done_next       = 1'b1;
            rsp_next.status = ST_RANGE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(req.block_number[BLOCK_W-1:5]);
            cur_next  = req.block_number[BLOCK_W-1:5];
          end
        end
      end
      S_SCAN: begin
        if (hit.found) begin
          // Claim the lowest free bit and write the word back
          ram_we                   = 1'b1;
          ram_wdata                = word | (WORD_BITS'(1) << hit.idx);
          done_next                = 1'b1;
          rsp_next.allocated_block = {cur, hit.idx};
          rsp_next.status          = ST_OK;
        end else if (cur == last_word) begin
          done_next       = 1'b1;
          rsp_next.status = ST_FULL;
        end else begin
          // Advance to the next word; no write is pending during a scan
          ram_re    = 1'b1;
          ram_raddr = AW'(cur + WIDX_W'(1));
          cur_next  = cur + WIDX_W'(1);
        end
      end
      S_FREE_CHK: begin
        done_next = 1'b1;
        if (!word[blk_q[4:0]]) begin
          rsp_next.status = ST_ALREADY_FREE;
        end else begin
          ram_we          = 1'b1;
          ram_wdata       = word & ~(WORD_BITS'(1) << blk_q[4:0]);
          rsp_next.status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (ram_we) begin
        word_valid[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid <= word_valid[ram_raddr];
      end
    end
  end

  // Payload registers: hold the block number, scan pointer and result beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      blk_q <= req.block_number;
    end
    cur <= cur_next;
    rsp <= rsp_next;
  end

endmodule
